@@ rtl/acsc_pkg.sv @@
// Shared types, constants and wrap helpers for the alarm clock set controller.
`default_nettype none
package acsc_pkg;

   localparam logic [4:0]  HOUR_MAX          = 5'd23;
   localparam logic [5:0]  MINUTE_MAX        = 6'd59;
   localparam logic [15:0] HALF_PERIOD_RESET = 16'd500;
   localparam logic [4:0]  ALARM_HOUR_RESET  = 5'd7;

   // Button bit positions within the level vector
   localparam int BTN_SET   = 0;
   localparam int BTN_UP    = 1;
   localparam int BTN_DOWN  = 2;
   localparam int BTN_ALARM = 3;

   typedef enum logic [1:0] {
      MODE_NORMAL    = 2'd0,
      MODE_SET_TIME  = 2'd1,
      MODE_SET_ALARM = 2'd2
   } mode_type;

   typedef enum logic {
      FIELD_HOUR   = 1'b0,
      FIELD_MINUTE = 1'b1
   } field_type;

   typedef struct packed {
      logic [3:0]  levels;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [31:0] time_ms;
   } sample_type;

   typedef struct packed {
      mode_type    mode;
      field_type   field_sel;
      logic [4:0]  edit_hour;
      logic [5:0]  edit_minute;
      logic [4:0]  alarm_hour;
      logic [5:0]  alarm_minute;
      logic        armed;
      logic        ringing;
      logic        beep_phase;
      logic        buzzer;
      logic [31:0] last_beep_ms;
      logic [3:0]  held;
   } state_type;

   typedef struct packed {
      mode_type    mode;
      field_type   field_sel;
      logic [4:0]  edit_hour;
      logic [5:0]  edit_minute;
      logic [4:0]  alarm_hour;
      logic [5:0]  alarm_minute;
      logic        armed;
      logic        ringing;
      logic        buzzer;
      logic        clock_write;
   } result_type;

   function automatic logic [4:0] hour_up(input logic [4:0] v);
      logic [4:0] n;
      n = v + 5'd1;
      return (n > HOUR_MAX) ? 5'd0 : n;
   endfunction

   function automatic logic [4:0] hour_down(input logic [4:0] v);
      return (v == 5'd0) ? HOUR_MAX : v - 5'd1;
   endfunction

   function automatic logic [5:0] minute_up(input logic [5:0] v);
      logic [5:0] n;
      n = v + 6'd1;
      return (n > MINUTE_MAX) ? 6'd0 : n;
   endfunction

   function automatic logic [5:0] minute_down(input logic [5:0] v);
      return (v == 6'd0) ? MINUTE_MAX : v - 6'd1;
   endfunction

endpackage
`default_nettype wire

@@ rtl/acsc_in_stage.sv @@
// Input register stage with its valid/stall handshake.
`default_nettype none
module acsc_in_stage
   import acsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire sample_type sample_in,
   input  wire logic       advance,
   output logic            stage_valid,
   output sample_type      stage_sample
);

   logic       valid_ff;
   sample_type sample_ff;
   logic       accept;

   assign req_stall    = valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign stage_valid  = valid_ff;
   assign stage_sample = sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   // Payload loads only on an accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= sample_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/acsc_step_logic.sv @@
// Next-state logic for one poll sample: buttons, alarm match and buzzer timing.
`default_nettype none
module acsc_step_logic
   import acsc_pkg::*;
(
   input  wire state_type  state_cur,
   input  wire sample_type smp,
   input  wire logic [15:0] half_period,
   output state_type       state_nxt,
   output logic            clock_write
);

   state_type   s;
   logic        cw;
   logic [3:0]  rise;
   logic [31:0] elapsed;

   assign state_nxt   = s;
   assign clock_write = cw;
   assign elapsed     = smp.time_ms - state_cur.last_beep_ms;

   always_comb begin
      s      = state_cur;
      cw     = 1'b0;
      rise   = smp.levels & ~state_cur.held;
      s.held = smp.levels;

      if (rise[BTN_SET]) begin
         case (s.mode)
            MODE_NORMAL: begin
               s.mode        = MODE_SET_TIME;
               s.edit_hour   = smp.hour;
               s.edit_minute = smp.minute;
            end
            MODE_SET_TIME: begin
               cw     = 1'b1;
               s.mode = MODE_SET_ALARM;
            end
            default: begin
               s.mode = MODE_NORMAL;
            end
         endcase
         s.field_sel = FIELD_HOUR;
      end

      if (rise[BTN_UP]) begin
         if (s.mode == MODE_SET_TIME) begin
            if (s.field_sel == FIELD_HOUR) s.edit_hour = hour_up(s.edit_hour);
            else s.edit_minute = minute_up(s.edit_minute);
         end else if (s.mode == MODE_SET_ALARM) begin
            if (s.field_sel == FIELD_HOUR) s.alarm_hour = hour_up(s.alarm_hour);
            else s.alarm_minute = minute_up(s.alarm_minute);
         end
      end

      if (rise[BTN_DOWN]) begin
         if (s.mode == MODE_SET_TIME) begin
            if (s.field_sel == FIELD_HOUR) s.edit_hour = hour_down(s.edit_hour);
            else s.edit_minute = minute_down(s.edit_minute);
         end else if (s.mode == MODE_SET_ALARM) begin
            if (s.field_sel == FIELD_HOUR) s.alarm_hour = hour_down(s.alarm_hour);
            else s.alarm_minute = minute_down(s.alarm_minute);
         end
      end

      if (rise[BTN_ALARM]) begin
         if (s.mode == MODE_NORMAL) begin
            // stop a ring, keep the beep phase
            if (s.ringing) begin
               s.ringing = 1'b0;
               s.buzzer  = 1'b0;
            end else begin
               s.armed = ~s.armed;
            end
         end else begin
            s.field_sel = (s.field_sel == FIELD_HOUR) ? FIELD_MINUTE : FIELD_HOUR;
         end
      end

      if (s.mode == MODE_NORMAL) begin
         if (s.armed && !s.ringing && smp.hour == s.alarm_hour &&
             smp.minute == s.alarm_minute && smp.second == 6'd0) begin
            s.ringing = 1'b1;
         end
         if (s.ringing) begin
            if (elapsed > {16'd0, half_period}) begin
               s.beep_phase   = ~s.beep_phase;
               s.buzzer       = s.beep_phase;
               s.last_beep_ms = smp.time_ms;
            end
         end else begin
            s.buzzer = 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

@@ rtl/alarm_clock_set_controller_core.sv @@
// Top level of the alarm clock set controller: state, result register and ports.
//
// The block takes one poll sample per clock cycle while req_stall is low and
// returns one result beat for each accepted sample: the sample is held in
// an input register, the step logic works out the new controller state in a
// single pass, and state and result are written together into registers. A
// result held by rsp_stall stalls the input register, and with it req_stall,
// only once both stages are full. The buzzer half period is written through
// the csr_ port, which is always ready; write it only while no sample is in
// flight.
`default_nettype none
module alarm_clock_set_controller_core
   import acsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_wdata,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_set_level,
   input  wire logic        req_up_level,
   input  wire logic        req_down_level,
   input  wire logic        req_alarm_level,
   input  wire logic [4:0]  req_current_hour,
   input  wire logic [5:0]  req_current_minute,
   input  wire logic [5:0]  req_current_second,
   input  wire logic [31:0] req_time_ms,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_mode,
   output logic             rsp_field_select,
   output logic [4:0]       rsp_edit_hour,
   output logic [5:0]       rsp_edit_minute,
   output logic [4:0]       rsp_alarm_hour_out,
   output logic [5:0]       rsp_alarm_minute_out,
   output logic             rsp_alarm_armed,
   output logic             rsp_ringing,
   output logic             rsp_buzzer_on,
   output logic             rsp_clock_write
);

   logic [15:0] half_period_ff;
   state_type   state_ff;
   state_type   state_in;
   result_type  result_ff;
   logic        rsp_valid_ff;
   logic        stage_valid;
   sample_type  stage_sample;
   sample_type  sample_in;
   logic        advance;
   logic        cw;

   localparam state_type STATE_RESET = '{
      mode:         MODE_NORMAL,
      field_sel:    FIELD_HOUR,
      edit_hour:    5'd0,
      edit_minute:  6'd0,
      alarm_hour:   ALARM_HOUR_RESET,
      alarm_minute: 6'd0,
      armed:        1'b0,
      ringing:      1'b0,
      beep_phase:   1'b0,
      buzzer:       1'b0,
      last_beep_ms: 32'd0,
      held:         4'd0
   };

   assign csr_ready = 1'b1;

   assign sample_in.levels  = {req_alarm_level, req_down_level, req_up_level, req_set_level};
   assign sample_in.hour    = req_current_hour;
   assign sample_in.minute  = req_current_minute;
   assign sample_in.second  = req_current_second;
   assign sample_in.time_ms = req_time_ms;

   // Move a sample forward when the result register is free or being drained
   assign advance = stage_valid && (!rsp_valid_ff || !rsp_stall);

   acsc_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .sample_in    (sample_in),
      .advance      (advance),
      .stage_valid  (stage_valid),
      .stage_sample (stage_sample)
   );

   acsc_step_logic u_step_logic (
      .state_cur   (state_ff),
      .smp         (stage_sample),
      .half_period (half_period_ff),
      .state_nxt   (state_in),
      .clock_write (cw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         state_ff       <= STATE_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            half_period_ff <= csr_wdata;
         end
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff.mode         <= state_in.mode;
         result_ff.field_sel    <= state_in.field_sel;
         result_ff.edit_hour    <= state_in.edit_hour;
         result_ff.edit_minute  <= state_in.edit_minute;
         result_ff.alarm_hour   <= state_in.alarm_hour;
         result_ff.alarm_minute <= state_in.alarm_minute;
         result_ff.armed        <= state_in.armed;
         result_ff.ringing      <= state_in.ringing;
         result_ff.buzzer       <= state_in.buzzer;
         result_ff.clock_write  <= cw;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_mode             = result_ff.mode;
   assign rsp_field_select     = result_ff.field_sel;
   assign rsp_edit_hour        = result_ff.edit_hour;
   assign rsp_edit_minute      = result_ff.edit_minute;
   assign rsp_alarm_hour_out   = result_ff.alarm_hour;
   assign rsp_alarm_minute_out = result_ff.alarm_minute;
   assign rsp_alarm_armed      = result_ff.armed;
   assign rsp_ringing          = result_ff.ringing;
   assign rsp_buzzer_on        = result_ff.buzzer;
   assign rsp_clock_write      = result_ff.clock_write;

   // A clock write only ever leaves set-time for set-alarm
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clock_write |-> rsp_mode == MODE_SET_ALARM)
      else $error("clock write outside set-alarm entry");

   // The alarm can only ring while armed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ringing |-> rsp_alarm_armed)
      else $error("ringing while disarmed");

   // In normal mode the buzzer sounds only while ringing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode == MODE_NORMAL && rsp_buzzer_on |-> rsp_ringing)
      else $error("buzzer on without ringing in normal mode");

   // Stored alarm time stays in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alarm_hour_out <= HOUR_MAX && rsp_alarm_minute_out <= MINUTE_MAX)
      else $error("alarm time out of range");

endmodule
`default_nettype wire

@@ tb/alarm_clock_set_controller_core_tb.sv @@
// Self-checking testbench for the alarm clock set controller core.
`default_nettype none
module alarm_clock_set_controller_core_tb
   import acsc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] B_NONE  = 4'd0;
   localparam logic [3:0] B_SET   = 4'(1 << BTN_SET);
   localparam logic [3:0] B_UP    = 4'(1 << BTN_UP);
   localparam logic [3:0] B_DOWN  = 4'(1 << BTN_DOWN);
   localparam logic [3:0] B_ALARM = 4'(1 << BTN_ALARM);

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic        req_set_level;
   logic        req_up_level;
   logic        req_down_level;
   logic        req_alarm_level;
   logic [4:0]  req_current_hour;
   logic [5:0]  req_current_minute;
   logic [5:0]  req_current_second;
   logic [31:0] req_time_ms;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_mode;
   logic        rsp_field_select;
   logic [4:0]  rsp_edit_hour;
   logic [5:0]  rsp_edit_minute;
   logic [4:0]  rsp_alarm_hour_out;
   logic [5:0]  rsp_alarm_minute_out;
   logic        rsp_alarm_armed;
   logic        rsp_ringing;
   logic        rsp_buzzer_on;
   logic        rsp_clock_write;

   alarm_clock_set_controller_core u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_set_level        (req_set_level),
      .req_up_level         (req_up_level),
      .req_down_level       (req_down_level),
      .req_alarm_level      (req_alarm_level),
      .req_current_hour     (req_current_hour),
      .req_current_minute   (req_current_minute),
      .req_current_second   (req_current_second),
      .req_time_ms          (req_time_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_mode             (rsp_mode),
      .rsp_field_select     (rsp_field_select),
      .rsp_edit_hour        (rsp_edit_hour),
      .rsp_edit_minute      (rsp_edit_minute),
      .rsp_alarm_hour_out   (rsp_alarm_hour_out),
      .rsp_alarm_minute_out (rsp_alarm_minute_out),
      .rsp_alarm_armed      (rsp_alarm_armed),
      .rsp_ringing          (rsp_ringing),
      .rsp_buzzer_on        (rsp_buzzer_on),
      .rsp_clock_write      (rsp_clock_write)
   );

   // Controller shadow state
   mode_type    ctl_mode;
   field_type   ctl_field;
   logic [4:0]  ctl_edit_hour;
   logic [5:0]  ctl_edit_minute;
   logic [4:0]  ctl_alarm_hour;
   logic [5:0]  ctl_alarm_minute;
   logic        ctl_armed;
   logic        ctl_ringing;
   logic        ctl_phase;
   logic        ctl_buzzer;
   logic [31:0] ctl_last_beep;
   logic [3:0]  ctl_held;
   logic [15:0] ctl_half_period;

   result_type  due_results[$];
   logic [31:0] ms_now;
   int          req_idle_pct;
   int          rsp_idle_pct;
   int          n_errors;
   int          n_sent;
   int          n_checked;
   int          n_clock_writes;
   int          n_rings;

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(0, 99) < rsp_idle_pct);
   end

   function automatic logic [4:0] nudge_hour(input logic [4:0] v, input bit up);
      logic [4:0] n;
      if (up) begin
         n = v + 5'd1;
         return (n > HOUR_MAX) ? 5'd0 : n;
      end
      return (v == 5'd0) ? HOUR_MAX : v - 5'd1;
   endfunction

   function automatic logic [5:0] nudge_minute(input logic [5:0] v, input bit up);
      logic [5:0] n;
      if (up) begin
         n = v + 6'd1;
         return (n > MINUTE_MAX) ? 6'd0 : n;
      end
      return (v == 6'd0) ? MINUTE_MAX : v - 6'd1;
   endfunction

   function automatic result_type advance_controller(input sample_type s);
      result_type  r;
      logic [3:0]  rise;
      logic [31:0] elapsed;
      bit          up;
      rise = s.levels & ~ctl_held;
      ctl_held = s.levels;
      r.clock_write = 1'b0;

      if (rise[BTN_SET]) begin
         case (ctl_mode)
            MODE_NORMAL: begin
               ctl_mode        = MODE_SET_TIME;
               ctl_edit_hour   = s.hour;
               ctl_edit_minute = s.minute;
            end
            MODE_SET_TIME: begin
               ctl_mode      = MODE_SET_ALARM;
               r.clock_write = 1'b1;
            end
            default: ctl_mode = MODE_NORMAL;
         endcase
         ctl_field = FIELD_HOUR;
      end

      // up is handled before down
      for (int d = 0; d < 2; d++) begin
         up = (d == 0);
         if (rise[up ? BTN_UP : BTN_DOWN]) begin
            if (ctl_mode == MODE_SET_TIME) begin
               if (ctl_field == FIELD_HOUR) ctl_edit_hour = nudge_hour(ctl_edit_hour, up);
               else ctl_edit_minute = nudge_minute(ctl_edit_minute, up);
            end else if (ctl_mode == MODE_SET_ALARM) begin
               if (ctl_field == FIELD_HOUR) ctl_alarm_hour = nudge_hour(ctl_alarm_hour, up);
               else ctl_alarm_minute = nudge_minute(ctl_alarm_minute, up);
            end
         end
      end

      if (rise[BTN_ALARM]) begin
         if (ctl_mode == MODE_NORMAL) begin
            if (ctl_ringing) begin
               ctl_ringing = 1'b0;
               ctl_buzzer  = 1'b0;
            end else begin
               ctl_armed = ~ctl_armed;
            end
         end else begin
            ctl_field = (ctl_field == FIELD_HOUR) ? FIELD_MINUTE : FIELD_HOUR;
         end
      end

      // edit modes freeze the alarm and buzzer
      if (ctl_mode == MODE_NORMAL) begin
         if (ctl_armed && !ctl_ringing && s.hour == ctl_alarm_hour &&
             s.minute == ctl_alarm_minute && s.second == 6'd0) begin
            ctl_ringing = 1'b1;
            n_rings++;
         end
         if (ctl_ringing) begin
            elapsed = s.time_ms - ctl_last_beep;
            if (elapsed > {16'd0, ctl_half_period}) begin
               ctl_phase     = ~ctl_phase;
               ctl_buzzer    = ctl_phase;
               ctl_last_beep = s.time_ms;
            end
         end else begin
            ctl_buzzer = 1'b0;
         end
      end

      r.mode         = ctl_mode;
      r.field_sel    = ctl_field;
      r.edit_hour    = ctl_edit_hour;
      r.edit_minute  = ctl_edit_minute;
      r.alarm_hour   = ctl_alarm_hour;
      r.alarm_minute = ctl_alarm_minute;
      r.armed        = ctl_armed;
      r.ringing      = ctl_ringing;
      r.buzzer       = ctl_buzzer;
      return r;
   endfunction

   task automatic compare_field(input string label, input logic [31:0] want,
                                input logic [31:0] seen);
      if (want !== seen) begin
         n_errors++;
         if (n_errors <= 100)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, seen);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            n_errors++;
            if (n_errors <= 100)
               $display("%0t: result beat with nothing expected, expected none, actual mode %0d",
                        $time, rsp_mode);
         end else begin
            want = due_results.pop_front();
            n_checked++;
            if (want.clock_write) n_clock_writes++;
            compare_field("mode", 32'(want.mode), 32'(rsp_mode));
            compare_field("field_select", 32'(want.field_sel), 32'(rsp_field_select));
            compare_field("edit_hour", 32'(want.edit_hour), 32'(rsp_edit_hour));
            compare_field("edit_minute", 32'(want.edit_minute), 32'(rsp_edit_minute));
            compare_field("alarm_hour_out", 32'(want.alarm_hour), 32'(rsp_alarm_hour_out));
            compare_field("alarm_minute_out", 32'(want.alarm_minute),
                          32'(rsp_alarm_minute_out));
            compare_field("alarm_armed", 32'(want.armed), 32'(rsp_alarm_armed));
            compare_field("ringing", 32'(want.ringing), 32'(rsp_ringing));
            compare_field("buzzer_on", 32'(want.buzzer), 32'(rsp_buzzer_on));
            compare_field("clock_write", 32'(want.clock_write), 32'(rsp_clock_write));
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_sample(input sample_type s);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid          = 1'b1;
      req_set_level      = s.levels[BTN_SET];
      req_up_level       = s.levels[BTN_UP];
      req_down_level     = s.levels[BTN_DOWN];
      req_alarm_level    = s.levels[BTN_ALARM];
      req_current_hour   = s.hour;
      req_current_minute = s.minute;
      req_current_second = s.second;
      req_time_ms        = s.time_ms;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due_results.push_back(advance_controller(s));
      n_sent++;
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [3:0] lv, input logic [4:0] hr,
                              input logic [5:0] mn, input logic [5:0] sc,
                              input logic [31:0] ms);
      sample_type s;
      s.levels  = lv;
      s.hour    = hr;
      s.minute  = mn;
      s.second  = sc;
      s.time_ms = ms;
      send_sample(s);
   endtask

   // Build a clock reading and timestamp; at_alarm steers the reading onto the alarm time.
   task automatic send_now(input logic [3:0] lv, input bit at_alarm);
      sample_type s;
      int         pick;
      pick = $urandom_range(0, 99);
      s.levels = lv;
      if (at_alarm) begin
         s.hour   = ctl_alarm_hour;
         s.minute = ctl_alarm_minute;
         s.second = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(1, 63)) : 6'd0;
      end else if (pick < 10) begin
         s.hour   = 5'($urandom_range(0, 31));
         s.minute = 6'($urandom_range(0, 63));
         s.second = 6'($urandom_range(0, 63));
      end else begin
         s.hour   = 5'($urandom_range(0, 23));
         s.minute = 6'($urandom_range(0, 59));
         s.second = (pick < 35) ? 6'd0 : 6'($urandom_range(0, 59));
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) ms_now = $urandom;
      else if (pick < 14) ms_now = ctl_last_beep + ctl_half_period;
      else if (pick < 24) ms_now = ctl_last_beep + ctl_half_period + 32'd1;
      else ms_now = ms_now + $urandom_range(0, ctl_half_period + 2);
      s.time_ms = ms_now;
      send_sample(s);
   endtask

   // Press, optionally hold for a beat or two, release
   task automatic tap(input logic [3:0] lv, input bit at_alarm);
      send_now(lv, at_alarm);
      repeat ($urandom_range(0, 2)) send_now(lv, at_alarm);
      send_now(B_NONE, at_alarm);
   endtask

   task automatic write_half_period(input logic [15:0] v);
      req_valid = 1'b0;
      while (due_results.size() != 0) @(negedge clock);
      csr_valid = 1'b1;
      csr_wdata = v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      ctl_half_period = v;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic ring_episode();
      while (ctl_mode != MODE_NORMAL) tap(B_SET, 1'b0);
      if (!ctl_armed && !ctl_ringing) tap(B_ALARM, 1'b0);
      repeat ($urandom_range(4, 16)) send_now(B_NONE, 1'b1);
      // sometimes carry the ring into the edit modes
      if ($urandom_range(0, 3) == 0) tap(B_SET, 1'b1);
      if ($urandom_range(0, 1) == 1) tap(B_ALARM, 1'b0);
   endtask

   task automatic tap_episode();
      int pick;
      repeat ($urandom_range(3, 12)) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) tap(B_SET, $urandom_range(0, 4) == 0);
         else if (pick < 45) tap(B_UP, 1'b0);
         else if (pick < 70) tap(B_DOWN, 1'b0);
         else if (pick < 90) tap(B_ALARM, 1'b0);
         else tap(4'($urandom_range(1, 15)), 1'b0);
      end
   endtask

   task automatic test_directed();
      send_fields(B_NONE, 5'd23, 6'd59, 6'd59, 32'd0);
      // enter set-time with an out-of-range reading
      send_fields(B_SET, 5'd31, 6'd63, 6'd0, 32'd10);
      send_fields(B_UP, 5'd0, 6'd0, 6'd0, 32'd20);
      send_fields(B_DOWN, 5'd0, 6'd0, 6'd0, 32'd30);
      send_fields(B_NONE, 5'd0, 6'd0, 6'd0, 32'd40);
      send_fields(B_UP, 5'd0, 6'd0, 6'd0, 32'd50);
      send_fields(B_ALARM, 5'd0, 6'd0, 6'd0, 32'd60);
      send_fields(B_UP, 5'd0, 6'd0, 6'd0, 32'd70);
      send_fields(B_DOWN, 5'd0, 6'd0, 6'd0, 32'd80);
      send_fields(B_NONE, 5'd0, 6'd0, 6'd0, 32'd90);
      // all four at once: handled in order set, up, down, alarm
      send_fields(B_SET | B_UP | B_DOWN | B_ALARM, 5'd12, 6'd30, 6'd0, 32'd100);
      send_fields(B_NONE, 5'd12, 6'd30, 6'd0, 32'd110);
      send_fields(B_DOWN, 5'd12, 6'd30, 6'd0, 32'd120);
      send_fields(B_SET, 5'd12, 6'd30, 6'd0, 32'd130);
      send_fields(B_ALARM, 5'd7, 6'd59, 6'd1, 32'd140);
      // alarm match, then buzzer on both sides of the half period
      send_fields(B_NONE, 5'd7, 6'd59, 6'd0, 32'd1000);
      send_fields(B_NONE, 5'd7, 6'd59, 6'd0, 32'd1500);
      send_fields(B_NONE, 5'd7, 6'd59, 6'd0, 32'd1501);
      send_fields(B_SET, 5'd16, 6'd32, 6'd0, 32'd1502);
      send_fields(B_NONE, 5'd16, 6'd32, 6'd0, 32'd1503);
      send_fields(B_SET, 5'd16, 6'd32, 6'd0, 32'd1504);
      send_fields(B_NONE, 5'd16, 6'd32, 6'd0, 32'd1505);
      send_fields(B_SET, 5'd16, 6'd32, 6'd0, 32'hFFFF_FFF0);
      // timestamp wraps past zero
      send_fields(B_NONE, 5'd16, 6'd33, 6'd0, 32'h0000_0300);
      send_fields(B_ALARM, 5'd16, 6'd33, 6'd0, 32'h0000_0301);
      ms_now = 32'h0000_0301;
   endtask

   task automatic test_half_period(input logic [15:0] v);
      write_half_period(v);
      repeat (2) ring_episode();
   endtask

   task automatic test_random(input int n_items, input logic [15:0] v);
      int stop_at;
      int pick;
      write_half_period(v);
      stop_at = n_sent + n_items;
      while (n_sent < stop_at) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) tap_episode();
         else if (pick < 7) ring_episode();
         else repeat ($urandom_range(2, 8))
            send_now(4'($urandom_range(0, 15)), $urandom_range(0, 5) == 0);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_wdata = 16'd0;
      req_valid = 1'b0;
      req_set_level = 1'b0;
      req_up_level = 1'b0;
      req_down_level = 1'b0;
      req_alarm_level = 1'b0;
      req_current_hour = 5'd0;
      req_current_minute = 6'd0;
      req_current_second = 6'd0;
      req_time_ms = 32'd0;
      rsp_stall = 1'b0;
      ctl_mode = MODE_NORMAL;
      ctl_field = FIELD_HOUR;
      ctl_edit_hour = 5'd0;
      ctl_edit_minute = 6'd0;
      ctl_alarm_hour = ALARM_HOUR_RESET;
      ctl_alarm_minute = 6'd0;
      ctl_armed = 1'b0;
      ctl_ringing = 1'b0;
      ctl_phase = 1'b0;
      ctl_buzzer = 1'b0;
      ctl_last_beep = 32'd0;
      ctl_held = 4'd0;
      ctl_half_period = HALF_PERIOD_RESET;
      ms_now = 32'd0;
      n_errors = 0;
      n_sent = 0;
      n_checked = 0;
      n_clock_writes = 0;
      n_rings = 0;
      req_idle_pct = 28;
      rsp_idle_pct = 52;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_half_period(16'd0);
      test_half_period(16'd1);
      test_random(380, 16'($urandom_range(1, 2000)));

      req_idle_pct = 52;
      rsp_idle_pct = 28;
      test_half_period(16'd65535);
      test_random(380, 16'($urandom_range(1, 8)));

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_half_period(HALF_PERIOD_RESET);
      test_random(380, 16'($urandom_range(0, 65535)));

      // drain, then give stray beats time to show
      req_valid = 1'b0;
      while (due_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);

      $display("Sent %0d poll samples, checked %0d result beats,", n_sent, n_checked);
      $display("%0d clock-set strobes, %0d rings; half periods 0, 1, 500, 65535 and random.",
               n_clock_writes, n_rings);
      if (n_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d results outstanding", due_results.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire

@@ files.f @@
rtl/acsc_pkg.sv
rtl/acsc_in_stage.sv
rtl/acsc_step_logic.sv
rtl/alarm_clock_set_controller_core.sv
tb/alarm_clock_set_controller_core_tb.sv
